>>> rtl/exact_fit_free_list_allocator_top_macros.svh
// assertion macros used by the allocator controller
`ifndef EXACT_FIT_FREE_LIST_ALLOCATOR_TOP_MACROS_SVH
`define EXACT_FIT_FREE_LIST_ALLOCATOR_TOP_MACROS_SVH

// same-cycle implication
`define EFL_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define EFL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/efl_pkg.sv
`default_nettype none

package efl_pkg;

   localparam int SIZE_W  = 24;
   localparam int LIMIT_W = 24;
   localparam int ADDR_W  = 23;
   localparam int STAT_W  = 3;

   localparam int FREE_ENTRIES_DEF = 16;
   localparam int ADDR_BITS_DEF    = 23;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 24'd8388607;

   localparam logic REQ_ALLOC   = 1'b0;
   localparam logic REQ_RELEASE = 1'b1;

   localparam logic [STAT_W-1:0] ST_REUSED   = 3'd0;
   localparam logic [STAT_W-1:0] ST_HEAP     = 3'd1;
   localparam logic [STAT_W-1:0] ST_OOM      = 3'd2;
   localparam logic [STAT_W-1:0] ST_FULL     = 3'd3;
   localparam logic [STAT_W-1:0] ST_RELEASED = 3'd4;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic scan;
      logic commit_hit;
      logic commit_miss;
   } efl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic match;
      logic last;
   } efl_stat_type;

endpackage

`default_nettype wire

>>> rtl/efl_datapath.sv
`default_nettype none

module efl_datapath #(
   parameter int FREE_ENTRIES = efl_pkg::FREE_ENTRIES_DEF,
   parameter int ADDR_BITS    = efl_pkg::ADDR_BITS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire efl_pkg::efl_cmd_type         cmd,
   output efl_pkg::efl_stat_type             stat,
   input  wire logic                         req_type,
   input  wire logic [efl_pkg::SIZE_W-1:0]   req_block_size,
   input  wire logic [efl_pkg::ADDR_W-1:0]   req_release_addr,
   input  wire logic                         csr_wr_en,
   input  wire logic [efl_pkg::LIMIT_W-1:0]  csr_wr_data,
   output logic      [efl_pkg::ADDR_W-1:0]   rsp_grant_addr,
   output logic      [efl_pkg::STAT_W-1:0]   rsp_status
);
   import efl_pkg::*;

   localparam int IDX_W  = $clog2(FREE_ENTRIES);
   localparam int COPY_W = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FREE_ENTRIES - 1);

   logic [SIZE_W-1:0]    size_mem [FREE_ENTRIES];
   logic [ADDR_BITS-1:0] addr_mem [FREE_ENTRIES];

   logic [FREE_ENTRIES-1:0] valid_ff, valid_in;
   logic [SIZE_W-1:0]       heap_top_ff, heap_top_in;
   logic [LIMIT_W-1:0]      limit_ff;

   logic                    type_ff;
   logic [SIZE_W-1:0]       size_ff;
   logic [ADDR_W-1:0]       addr_ff;

   logic [IDX_W-1:0]        scan_idx_ff, scan_idx_in;
   logic [IDX_W-1:0]        rd_idx_ff;
   logic                    rd_pend_ff, rd_pend_in;
   logic [SIZE_W-1:0]       rd_size_ff;
   logic [ADDR_BITS-1:0]    rd_addr_ff;

   logic [ADDR_W-1:0]       grant_ff, grant_in;
   logic [STAT_W-1:0]       status_ff, status_in;

   logic [ADDR_BITS-1:0]    store_addr;
   logic [ADDR_W-1:0]       reuse_addr;
   logic [SIZE_W:0]         new_top;
   logic                    top_over;
   logic                    oom;
   logic                    rd_valid;

   always_comb begin
      store_addr = '0;
      store_addr[COPY_W-1:0] = addr_ff[COPY_W-1:0];
      reuse_addr = '0;
      reuse_addr[COPY_W-1:0] = rd_addr_ff[COPY_W-1:0];
   end

   assign rd_valid = valid_ff[rd_idx_ff];

   always_comb begin
      stat.last = rd_pend_ff && (rd_idx_ff == LAST_IDX);
      if (type_ff == REQ_ALLOC) begin
         stat.match = rd_pend_ff && rd_valid && (rd_size_ff == size_ff);
      end else begin
         stat.match = rd_pend_ff && !rd_valid;
      end
   end

   // bump path: the top must fit the address width and stay within the limit
   assign new_top  = {1'b0, heap_top_ff} + {1'b0, size_ff};
   assign top_over = (heap_top_ff >> ADDR_BITS) != '0;
   assign oom      = (new_top > {1'b0, limit_ff}) || top_over;

   always_comb begin
      scan_idx_in = scan_idx_ff;
      rd_pend_in  = rd_pend_ff;
      valid_in    = valid_ff;
      heap_top_in = heap_top_ff;
      grant_in    = grant_ff;
      status_in   = status_ff;
      if (cmd.load) begin
         scan_idx_in = '0;
         rd_pend_in  = 1'b0;
      end else if (cmd.scan) begin
         rd_pend_in = 1'b1;
         if (scan_idx_ff != LAST_IDX) begin
            scan_idx_in = scan_idx_ff + 1'b1;
         end
      end
      if (cmd.commit_hit) begin
         if (type_ff == REQ_ALLOC) begin
            valid_in[rd_idx_ff] = 1'b0;
            grant_in  = reuse_addr;
            status_in = ST_REUSED;
         end else begin
            valid_in[rd_idx_ff] = 1'b1;
            grant_in  = '0;
            status_in = ST_RELEASED;
         end
      end else if (cmd.commit_miss) begin
         grant_in = '0;
         if (type_ff == REQ_RELEASE) begin
            status_in = ST_FULL;
         end else if (oom) begin
            status_in = ST_OOM;
         end else begin
            grant_in    = heap_top_ff[ADDR_W-1:0];
            status_in   = ST_HEAP;
            heap_top_in = new_top[SIZE_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         heap_top_ff <= '0;
         limit_ff    <= LIMIT_RESET;
         scan_idx_ff <= '0;
         rd_pend_ff  <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         heap_top_ff <= heap_top_in;
         scan_idx_ff <= scan_idx_in;
         rd_pend_ff  <= rd_pend_in;
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
      end
   end

   // request word and response payload
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         type_ff <= req_type;
         size_ff <= req_block_size;
         addr_ff <= req_release_addr;
      end
      grant_ff  <= grant_in;
      status_ff <= status_in;
   end

   // free table storage, one registered read port and one write port
   always_ff @(posedge clock) begin
      if (cmd.scan) begin
         rd_size_ff <= size_mem[scan_idx_ff];
         rd_addr_ff <= addr_mem[scan_idx_ff];
         rd_idx_ff  <= scan_idx_ff;
      end
      if (cmd.commit_hit && (type_ff == REQ_RELEASE)) begin
         size_mem[rd_idx_ff] <= size_ff;
         addr_mem[rd_idx_ff] <= store_addr;
      end
   end

   assign rsp_grant_addr = grant_ff;
   assign rsp_status     = status_ff;

endmodule

`default_nettype wire

>>> rtl/efl_ctrl.sv
`default_nettype none

module efl_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   output logic                       rsp_valid,
   output efl_pkg::efl_cmd_type       cmd,
   input  wire efl_pkg::efl_stat_type stat
);
   import efl_pkg::*;
   `include "exact_fit_free_list_allocator_top_macros.svh"

   typedef enum logic {
      IDLE,
      SCAN
   } state_type;

   state_type state_ff;
   logic      busy_ff;
   logic      rsp_valid_ff;
   logic      done;

   always_comb begin
      cmd.load        = (state_ff == IDLE) && start;
      cmd.scan        = (state_ff == SCAN);
      cmd.commit_hit  = (state_ff == SCAN) && stat.match;
      cmd.commit_miss = (state_ff == SCAN) && !stat.match && stat.last;
   end

   assign done = cmd.commit_hit || cmd.commit_miss;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= done;
         unique case (state_ff)
            IDLE: begin
               if (start) begin
                  state_ff <= SCAN;
                  busy_ff  <= 1'b1;
               end
            end
            SCAN: begin
               if (done) begin
                  state_ff <= IDLE;
                  busy_ff  <= 1'b0;
               end
            end
            default: begin
               state_ff <= IDLE;
               busy_ff  <= 1'b0;
            end
         endcase
      end
   end

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;

   `EFL_ASSERT_SAME(a_busy_state, clock, reset, 1'b1, busy_ff == (state_ff == SCAN), "busy out of step with state")
   `EFL_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy_ff, busy_ff && !rsp_valid_ff, "accepted word did not start a scan")
   `EFL_ASSERT_NEXT(a_commit_rsp, clock, reset, done, rsp_valid_ff && !busy_ff, "commit without a response strobe")
   `EFL_ASSERT_SAME(a_single_commit, clock, reset, 1'b1, !(cmd.commit_hit && cmd.commit_miss), "hit and miss commit together")

endmodule

`default_nettype wire

>>> rtl/exact_fit_free_list_allocator_top.sv
`default_nettype none

// channel   ports                                              handshake
// request   req_type, req_block_size, req_release_addr         start && !busy
// response  rsp_grant_addr, rsp_status                         rsp_valid, one cycle
// csr       csr_wr_data (heap limit)                           csr_wr_en
//
// a word scans the free table one entry per cycle through the table's read port,
// and the response comes once an entry matches or the last entry has been read,
// so a request finishes sooner when an entry matches early
// busy drops in the cycle the response strobe is shown, so the next start may
// be taken there
// reset is synchronous: valid bits, heap top and limit reset, table contents do not
// the response cannot be held off, it is valid for exactly one cycle

module exact_fit_free_list_allocator_top #(
   parameter int FREE_ENTRIES = efl_pkg::FREE_ENTRIES_DEF,
   parameter int ADDR_BITS    = efl_pkg::ADDR_BITS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire logic                         req_type,
   input  wire logic [efl_pkg::SIZE_W-1:0]   req_block_size,
   input  wire logic [efl_pkg::ADDR_W-1:0]   req_release_addr,
   output logic                              rsp_valid,
   output logic      [efl_pkg::ADDR_W-1:0]   rsp_grant_addr,
   output logic      [efl_pkg::STAT_W-1:0]   rsp_status,
   input  wire logic                         csr_wr_en,
   input  wire logic [efl_pkg::LIMIT_W-1:0]  csr_wr_data
);
   import efl_pkg::*;

   efl_cmd_type  cmd;
   efl_stat_type stat;

   efl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .stat      (stat)
   );

   efl_datapath #(
      .FREE_ENTRIES (FREE_ENTRIES),
      .ADDR_BITS    (ADDR_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_type         (req_type),
      .req_block_size   (req_block_size),
      .req_release_addr (req_release_addr),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .rsp_grant_addr   (rsp_grant_addr),
      .rsp_status       (rsp_status)
   );

endmodule

`default_nettype wire

>>> test/tb_exact_fit_free_list_allocator_top.sv
`default_nettype none

module tb_exact_fit_free_list_allocator_top;
   timeunit 1ns;
   timeprecision 1ps;

   import efl_pkg::*;

   localparam int ENTRIES        = FREE_ENTRIES_DEF;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int TAIL_CYCLES    = 40;
   localparam logic [SIZE_W-1:0] ADDR_SPAN = 24'd8388608;

   typedef struct packed {
      logic [ADDR_W-1:0] grant_addr;
      logic [STAT_W-1:0] status;
   } grant_word_type;

   logic                clock = 1'b0;
   logic                reset;
   logic                start;
   logic                busy;
   logic                req_type;
   logic [SIZE_W-1:0]   req_block_size;
   logic [ADDR_W-1:0]   req_release_addr;
   logic                rsp_valid;
   logic [ADDR_W-1:0]   rsp_grant_addr;
   logic [STAT_W-1:0]   rsp_status;
   logic                csr_wr_en;
   logic [LIMIT_W-1:0]  csr_wr_data;

   // shadow of the allocator state
   logic                model_valid [ENTRIES];
   logic [SIZE_W-1:0]   model_size  [ENTRIES];
   logic [ADDR_W-1:0]   model_addr  [ENTRIES];
   logic [SIZE_W-1:0]   model_top;
   logic [LIMIT_W-1:0]  model_limit;

   grant_word_type      pending_grants[$];
   int                  words_in_flight;
   int                  fail_count;
   int                  quiet_cycles;
   int                  sender_idle_pct;

   exact_fit_free_list_allocator_top u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_type         (req_type),
      .req_block_size   (req_block_size),
      .req_release_addr (req_release_addr),
      .rsp_valid        (rsp_valid),
      .rsp_grant_addr   (rsp_grant_addr),
      .rsp_status       (rsp_status),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   always #5 clock = ~clock;

   function automatic grant_word_type allocator_step(logic kind, logic [SIZE_W-1:0] size,
                                                     logic [ADDR_W-1:0] addr);
      grant_word_type   w;
      logic [SIZE_W:0]  new_top;
      bit               done;
      w.grant_addr = '0;
      w.status     = ST_OOM;
      done         = 1'b0;
      if (kind == REQ_ALLOC) begin
         // first exact fit wins, lowest entry first
         for (int i = 0; i < ENTRIES; i++) begin
            if (!done && model_valid[i] && model_size[i] == size) begin
               model_valid[i] = 1'b0;
               w.grant_addr   = model_addr[i];
               w.status       = ST_REUSED;
               done           = 1'b1;
            end
         end
         if (!done) begin
            new_top = {1'b0, model_top} + size;
            if (new_top <= {1'b0, model_limit} && model_top < ADDR_SPAN) begin
               w.grant_addr = model_top[ADDR_W-1:0];
               w.status     = ST_HEAP;
               model_top    = new_top[SIZE_W-1:0];
            end
         end
      end else begin
         w.status = ST_FULL;
         for (int i = 0; i < ENTRIES; i++) begin
            if (!done && !model_valid[i]) begin
               model_valid[i] = 1'b1;
               model_size[i]  = size;
               model_addr[i]  = addr;
               w.status       = ST_RELEASED;
               done           = 1'b1;
            end
         end
      end
      return w;
   endfunction

   always @(posedge clock) begin
      grant_word_type want;
      int             taken;
      int             done_words;
      taken      = 0;
      done_words = 0;
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) begin
            model_valid[i] = 1'b0;
            model_size[i]  = '0;
            model_addr[i]  = '0;
         end
         model_top   = '0;
         model_limit = LIMIT_RESET;
         pending_grants.delete();
         words_in_flight <= 0;
      end else begin
         if (rsp_valid) begin
            if (pending_grants.size() == 0) begin
               $display("%0t unexpected word: expected none, actual addr %h status %0d",
                        $time, rsp_grant_addr, rsp_status);
               fail_count++;
            end else begin
               want = pending_grants.pop_front();
               done_words = 1;
               if (rsp_grant_addr !== want.grant_addr) begin
                  $display("%0t grant_addr mismatch: expected %h, actual %h",
                           $time, want.grant_addr, rsp_grant_addr);
                  fail_count++;
               end
               if (rsp_status !== want.status) begin
                  $display("%0t status mismatch: expected %0d, actual %0d",
                           $time, want.status, rsp_status);
                  fail_count++;
               end
            end
         end
         if (csr_wr_en)
            model_limit = csr_wr_data;
         if (start && !busy) begin
            pending_grants.push_back(allocator_step(req_type, req_block_size,
                                                    req_release_addr));
            taken = 1;
         end
         words_in_flight <= words_in_flight + taken - done_words;
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t watchdog: nothing accepted for %0d cycles", $time, quiet_cycles);
         $display("tb_exact_fit_free_list_allocator_top NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_word(logic kind, logic [SIZE_W-1:0] size, logic [ADDR_W-1:0] addr);
      while ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start            <= 1'b1;
      req_type         <= kind;
      req_block_size   <= size;
      req_release_addr <= addr;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // hold off the sender until every outstanding word has come back
   task automatic wait_drained();
      start <= 1'b0;
      @(posedge clock);
      while (words_in_flight != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_heap_limit(logic [LIMIT_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic test_reset_limit();
      // reset limit sits one below the full address span asked for here
      send_word(REQ_ALLOC, ADDR_SPAN, '0);
   endtask

   task automatic test_tiny_limit();
      wait_drained();
      write_heap_limit(24'd1);
      send_word(REQ_ALLOC, 24'd2, '0);
      send_word(REQ_ALLOC, 24'd1, 23'h7fffff);
      // zero size grants the top without moving it
      send_word(REQ_ALLOC, 24'd0, '0);
   endtask

   task automatic test_free_table();
      send_word(REQ_RELEASE, 24'd5, 23'h7fffff);
      send_word(REQ_RELEASE, 24'd5, 23'h000000);
      send_word(REQ_ALLOC,   24'd5, '0);
      send_word(REQ_RELEASE, 24'd0, 23'h2aaaaa);
      send_word(REQ_ALLOC,   24'd0, '0);
   endtask

   task automatic test_table_full();
      send_word(REQ_RELEASE, ADDR_SPAN, 23'h555555);
      for (int i = 0; i < ENTRIES - 2; i++)
         send_word(REQ_RELEASE, SIZE_W'(i), ADDR_W'(23'h12345 * (i + 1)));
      send_word(REQ_RELEASE, 24'd7, 23'h7fffff);
      send_word(REQ_ALLOC, ADDR_SPAN, '0);
   endtask

   task automatic send_random_word();
      int pick;
      pick = $urandom_range(99);
      if (pick < 45)
         send_word(REQ_ALLOC, SIZE_W'($urandom_range(31)), ADDR_W'($urandom));
      else if (pick < 88)
         send_word(REQ_RELEASE, SIZE_W'($urandom_range(31)), ADDR_W'($urandom));
      else if (pick < 94)
         send_word(REQ_ALLOC, SIZE_W'($urandom_range(8388608)), ADDR_W'($urandom));
      else
         send_word(REQ_RELEASE, SIZE_W'($urandom_range(8388608)), ADDR_W'($urandom));
   endtask

   task automatic test_random_traffic(logic [LIMIT_W-1:0] limit, int idle_pct, int words);
      wait_drained();
      write_heap_limit(limit);
      sender_idle_pct = idle_pct;
      for (int n = 0; n < words; n++) begin
         send_random_word();
         if ($urandom_range(199) == 0)
            wait_drained();
      end
   endtask

   task automatic test_heap_top_extreme();
      wait_drained();
      write_heap_limit(ADDR_SPAN);
      sender_idle_pct = 0;
      // climb exactly to the end of the address range, then nothing more fits on the heap
      send_word(REQ_ALLOC, ADDR_SPAN - model_top, '0);
      send_word(REQ_ALLOC, 24'd0, '0);
      send_word(REQ_ALLOC, 24'd1, '0);
   endtask

   initial begin
      fail_count       = 0;
      sender_idle_pct  = 6;
      reset            <= 1'b1;
      start            <= 1'b0;
      req_type         <= REQ_ALLOC;
      req_block_size   <= '0;
      req_release_addr <= '0;
      csr_wr_en        <= 1'b0;
      csr_wr_data      <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_limit();
      test_tiny_limit();
      test_free_table();
      test_table_full();
      test_random_traffic(24'd4096, 6, 560);
      test_random_traffic(24'd1048576, 78, 560);
      test_random_traffic(LIMIT_RESET, 0, 580);
      test_heap_top_extreme();

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_grants.size() != 0) begin
         $display("%0t words outstanding: expected 0, actual %0d",
                  $time, pending_grants.size());
         fail_count++;
      end
      if (fail_count == 0)
         $display("tb_exact_fit_free_list_allocator_top OK");
      else
         $display("tb_exact_fit_free_list_allocator_top NOT OK");
      $finish;
   end

endmodule

`default_nettype wire
